// ----- hdl/sms_pkg.sv -----
// Shared constants, types and helpers for the SUBLEQ step core.
// No dependencies; used by sms_mem and subleq_machine_step_core.
package sms_pkg;

  // Memory geometry (word count is a power of two)
  localparam int MEM_WORDS = 32768;
  localparam int MEM_AW    = $clog2(MEM_WORDS);
  localparam int WORD_W    = 32;
  localparam int PC_W      = 15;
  localparam int WIDTH_W   = 6;

  localparam logic [WIDTH_W-1:0] WIDTH_RESET = 6'd16;
  localparam logic [WIDTH_W-1:0] WIDTH_MIN   = 6'd8;
  localparam logic [WIDTH_W-1:0] WIDTH_MAX   = 6'd32;

  // Request opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_OPER,
    S_TGT,
    S_EXEC
  } state_t;

  // Memory write port request
  typedef struct packed {
    logic              en;
    logic [MEM_AW-1:0] addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

  // Clamp the configured width into the legal range
  function automatic logic [WIDTH_W-1:0] width_clamp(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] e;
    e = w;
    if (e < WIDTH_MIN) e = WIDTH_MIN;
    if (e > WIDTH_MAX) e = WIDTH_MAX;
    return e;
  endfunction

  // All ones in the low width bits
  function automatic logic [WORD_W-1:0] width_mask(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] e;
    e = width_clamp(w);
    return {WORD_W{1'b1}} >> (WIDTH_MAX - e);
  endfunction

  // Sign bit of a word of the given width
  function automatic logic [WORD_W-1:0] width_sign(input logic [WIDTH_W-1:0] w);
    logic [WIDTH_W-1:0] e;
    e = width_clamp(w);
    return {{(WORD_W-1){1'b0}}, 1'b1} << (e - 6'd1);
  endfunction

endpackage

// ----- hdl/sms_mem.sv -----
// Main memory: one write port, two registered read ports, and the
// zeroing sweep that runs after reset. Depends on sms_pkg.
module sms_mem (
  input  logic                                clk,
  input  logic                                rst,
  input  sms_pkg::mem_wr_t                    wr,
  input  logic [sms_pkg::MEM_AW-1:0]          rd_addr0,
  input  logic [sms_pkg::MEM_AW-1:0]          rd_addr1,
  output logic [sms_pkg::WORD_W-1:0]          rd_data0,
  output logic [sms_pkg::WORD_W-1:0]          rd_data1,
  output logic                                busy
);

  logic [sms_pkg::WORD_W-1:0] mem [sms_pkg::MEM_WORDS];
  logic [sms_pkg::MEM_AW-1:0] clr_addr;

  // Zeroing sweep, one word a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      busy     <= 1'b1;
    end else if (busy) begin
      clr_addr <= clr_addr + sms_pkg::MEM_AW'(1);
      if (clr_addr == sms_pkg::MEM_AW'(sms_pkg::MEM_WORDS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Write port, sweep has priority
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= '0;
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read ports, registered; data follows the address in the next cycle
  always_ff @(posedge clk) begin
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

// ----- hdl/subleq_machine_step_core.sv -----
// SUBLEQ step core: one request loads a word or runs one instruction.
// A step goes from dispatch via S_OPER, S_TGT, S_EXEC to the result register;
// loads and halted steps go there from idle. Steps run one at a time on the two
// read ports (pc/pc+1, mem[a]/mem[b], pc+2, then write back); one more request
// can wait in the pending slot. Requests stall while reset zeroes 32768 words.
// Depends on sms_pkg and sms_mem.
module subleq_machine_step_core (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sms_pkg::WIDTH_W-1:0]         cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                opcode,
  input  logic [14:0]                         load_address,
  input  logic [31:0]                         load_data,
  input  logic [7:0]                          in_byte,
  input  logic                                in_eof,
  // result channel
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic                                out_valid,
  output logic [7:0]                          out_byte,
  output logic                                input_taken,
  output logic                                halted,
  output logic [14:0]                         next_pc
);

  localparam int AW = sms_pkg::MEM_AW;
  localparam int WW = sms_pkg::WORD_W;
  localparam int PW = sms_pkg::PC_W;

  sms_pkg::state_t  state, state_next;
  sms_pkg::mem_wr_t wr;

  logic [AW-1:0] rd_addr0, rd_addr1;
  logic [WW-1:0] rd_data0, rd_data1;
  logic          mem_busy;

  // word width derived values
  logic [WW-1:0] mask, sign;

  // pending request
  logic          pend_valid;
  logic          pend_op;
  logic [14:0]   pend_addr;
  logic [31:0]   pend_data;
  logic [7:0]    pend_byte;
  logic          pend_eof;

  // architectural state
  logic [PW-1:0] pc, pc_next;
  logic          halt_flag, halt_next;

  // instruction in flight
  logic [WW-1:0] a_q, b_q, r_q;
  logic [7:0]    ma_byte;
  logic          is_in, is_out, jmp;
  logic [7:0]    in_byte_q;
  logic          in_eof_q;

  // control
  logic take, emit, can_emit;
  logic res_out_valid_next, res_taken_next;
  logic [7:0] res_byte_next;
  logic [WW-1:0] r_next;
  logic [PW:0] pc_plus3;

  sms_mem u_mem (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1),
    .busy     (mem_busy)
  );

  // Configuration register, kept as mask and sign
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= sms_pkg::width_mask(sms_pkg::WIDTH_RESET);
      sign <= sms_pkg::width_sign(sms_pkg::WIDTH_RESET);
    end else if (cfg_valid && cfg_ready) begin
      mask <= sms_pkg::width_mask(cfg_data);
      sign <= sms_pkg::width_sign(cfg_data);
    end
  end

  // Pending request slot
  assign in_stall = pend_valid || mem_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      pend_valid <= 1'b1;
    end else if (take) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      pend_op   <= opcode;
      pend_addr <= load_address;
      pend_data <= load_data;
      pend_byte <= in_byte;
      pend_eof  <= in_eof;
    end
  end

  assign can_emit = !res_valid || !res_stall;
  assign pc_plus3 = {1'b0, pc} + (PW+1)'(3);
  assign r_next   = (rd_data1 - rd_data0) & mask;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sms_pkg::S_IDLE: begin
        if (!mem_busy && pend_valid && pend_op == sms_pkg::OP_STEP && !halt_flag) begin
          state_next = sms_pkg::S_OPER;
        end
      end
      sms_pkg::S_OPER: state_next = sms_pkg::S_TGT;
      sms_pkg::S_TGT:  state_next = sms_pkg::S_EXEC;
      sms_pkg::S_EXEC: begin
        if (can_emit) state_next = sms_pkg::S_IDLE;
      end
      default: state_next = sms_pkg::S_IDLE;
    endcase
  end

  // Outputs of the sequencer: reads, write, result, pc update
  always_comb begin
    take               = 1'b0;
    emit               = 1'b0;
    wr                 = '0;
    rd_addr0           = pc[AW-1:0];
    rd_addr1           = AW'(pc + PW'(1));
    pc_next            = pc;
    halt_next          = halt_flag;
    res_out_valid_next = 1'b0;
    res_byte_next      = '0;
    res_taken_next     = 1'b0;
    case (state)
      sms_pkg::S_IDLE: begin
        if (!mem_busy && pend_valid) begin
          if (pend_op == sms_pkg::OP_LOAD) begin
            if (can_emit) begin
              take    = 1'b1;
              emit    = 1'b1;
              wr.en   = 1'b1;
              wr.addr = pend_addr[AW-1:0];
              wr.data = pend_data & mask;
            end
          end else if (halt_flag) begin
            if (can_emit) begin
              take = 1'b1;
              emit = 1'b1;
            end
          end else begin
            take = 1'b1;
          end
        end
      end
      sms_pkg::S_OPER: begin
        rd_addr0 = rd_data0[AW-1:0];
        rd_addr1 = rd_data1[AW-1:0];
      end
      sms_pkg::S_TGT: begin
        rd_addr0 = AW'(pc + PW'(2));
      end
      sms_pkg::S_EXEC: begin
        // hold the pc+2 read so c stays put while the result waits
        rd_addr0 = AW'(pc + PW'(2));
        if (can_emit) begin
          emit    = 1'b1;
          wr.addr = b_q[AW-1:0];
          if (is_in) begin
            wr.en          = 1'b1;
            wr.data        = in_eof_q ? mask : ({{(WW-8){1'b0}}, in_byte_q} & mask);
            res_taken_next = 1'b1;
          end else if (is_out) begin
            res_out_valid_next = 1'b1;
            res_byte_next      = ma_byte;
          end else begin
            wr.en   = 1'b1;
            wr.data = r_q;
          end
          if (!is_in && !is_out && jmp) begin
            pc_next   = rd_data0[PW-1:0];
            halt_next = |rd_data0[WW-1:PW];
          end else begin
            pc_next   = pc_plus3[PW-1:0];
            halt_next = pc_plus3[PW];
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sms_pkg::S_IDLE;
      pc        <= '0;
      halt_flag <= 1'b0;
    end else begin
      state     <= state_next;
      pc        <= pc_next;
      halt_flag <= halt_next;
    end
  end

  // Instruction operands and decode
  always_ff @(posedge clk) begin
    if (state == sms_pkg::S_IDLE && take) begin
      in_byte_q <= pend_byte;
      in_eof_q  <= pend_eof;
    end
    if (state == sms_pkg::S_OPER) begin
      a_q <= rd_data0;
      b_q <= rd_data1;
    end
    if (state == sms_pkg::S_TGT) begin
      is_in   <= (a_q == mask);
      is_out  <= (b_q == mask);
      r_q     <= r_next;
      jmp     <= (r_next == '0) || ((r_next & sign) != '0);
      ma_byte <= rd_data0[7:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_valid   <= res_out_valid_next;
      out_byte    <= res_byte_next;
      input_taken <= res_taken_next;
      halted      <= halt_next;
      next_pc     <= pc_next;
    end
  end

  // Checks
  a_clear_stalls: assert property (@(posedge clk) disable iff (rst)
    mem_busy |-> in_stall)
    else $error("request accepted during memory clear");

  a_oper_not_halted: assert property (@(posedge clk) disable iff (rst)
    (state == sms_pkg::S_OPER) |-> !halt_flag)
    else $error("instruction started while halted");

  a_oper_to_tgt: assert property (@(posedge clk) disable iff (rst)
    (state == sms_pkg::S_OPER) |=> (state == sms_pkg::S_TGT))
    else $error("sequencer left operand fetch wrongly");

  a_write_place: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (emit && (state == sms_pkg::S_IDLE || state == sms_pkg::S_EXEC)))
    else $error("memory write outside load or execute");

endmodule

// ----- tb/sv/subleq_machine_step_core_tb.sv -----
// Self-checking testbench for the SUBLEQ step core: directed table, random programs, closing halt.
// Predicts results from its own machine image or the table's rows; depends on sms_pkg and the core RTL.
`timescale 1ns / 100ps

module subleq_machine_step_core_tb;

  // Request opcodes, taken from the package
  localparam bit OP_LOAD = sms_pkg::OP_LOAD;
  localparam bit OP_STEP = sms_pkg::OP_STEP;

  typedef struct packed {
    bit        opcode;
    bit [14:0] load_address;
    bit [31:0] load_data;
    bit [7:0]  in_byte;
    bit        in_eof;
  } sms_req_t;

  typedef struct packed {
    bit        out_valid;
    bit [7:0]  out_byte;
    bit        input_taken;
    bit        halted;
    bit [14:0] next_pc;
  } step_result_t;

  typedef struct packed {
    bit [5:0]     width;
    sms_req_t     req;
    bit           typed;
    step_result_t want;
  } dir_row_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [sms_pkg::WIDTH_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 opcode;
  logic [14:0]          load_address;
  logic [31:0]          load_data;
  logic [7:0]           in_byte;
  logic                 in_eof;
  logic                 res_valid;
  logic                 res_stall;
  logic                 out_valid;
  logic [7:0]           out_byte;
  logic                 input_taken;
  logic                 halted;
  logic [14:0]          next_pc;

  // Machine image kept by the testbench
  bit [31:0]    mem_img [0:32767];
  bit [14:0]    pc_img;
  bit           halt_img;
  bit [5:0]     width_reg;

  step_result_t pending_results [$];
  dir_row_t     dir_rows [$];
  step_result_t oldest;
  int           errors;
  int           items_sent;
  int           results_seen;
  int           width_writes;
  int           burst_left;
  int           stall_left;
  int           stall_mode;
  int           stall_phase;

  subleq_machine_step_core DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .load_address (load_address),
    .load_data    (load_data),
    .in_byte      (in_byte),
    .in_eof       (in_eof),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .out_valid    (out_valid),
    .out_byte     (out_byte),
    .input_taken  (input_taken),
    .halted       (halted),
    .next_pc      (next_pc)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // Width register value as the machine uses it
  function automatic bit [5:0] eff_bits(bit [5:0] w);
    if (w < 6'd8) return 6'd8;
    if (w > 6'd32) return 6'd32;
    return w;
  endfunction

  function automatic bit [31:0] word_mask(bit [5:0] w);
    bit [63:0] m;
    m = (64'd1 << eff_bits(w)) - 64'd1;
    return m[31:0];
  endfunction

  // One request against the image; state only changes when commit is set
  function automatic step_result_t subleq_exec(sms_req_t r, bit commit);
    step_result_t res;
    bit [31:0]    msk, sgn, a, b, c, nxt, diff, v;
    bit [14:0]    pc_nx;
    bit           halt_nx;
    res = '0;
    msk = word_mask(width_reg);
    sgn = 32'd1 << (eff_bits(width_reg) - 6'd1);
    pc_nx = pc_img;
    halt_nx = halt_img;
    if (r.opcode == OP_LOAD) begin
      if (commit) mem_img[r.load_address] = r.load_data & msk;
    end else if (!halt_img) begin
      a = mem_img[pc_img];
      b = mem_img[15'(pc_img + 15'd1)];
      c = mem_img[15'(pc_img + 15'd2)];
      nxt = {17'd0, pc_img} + 32'd3;
      if (a == msk) begin
        // input: byte, or all ones at end of file
        v = r.in_eof ? msk : ({24'd0, r.in_byte} & msk);
        if (commit) mem_img[b[14:0]] = v;
        res.input_taken = 1'b1;
      end else if (b == msk) begin
        res.out_valid = 1'b1;
        res.out_byte = mem_img[a[14:0]][7:0];
      end else begin
        diff = (mem_img[b[14:0]] - mem_img[a[14:0]]) & msk;
        if (commit) mem_img[b[14:0]] = diff;
        if (diff == 32'd0 || (diff & sgn) != 32'd0) nxt = c;
      end
      if (nxt >= 32'd32768) halt_nx = 1'b1;
      pc_nx = nxt[14:0];
    end
    if (commit) begin
      pc_img = pc_nx;
      halt_img = halt_nx;
    end
    res.halted = halt_nx;
    res.next_pc = pc_nx;
    return res;
  endfunction

  function automatic void add_row(bit [5:0] w, bit op, bit [14:0] addr, bit [31:0] data,
                                  bit [7:0] ib, bit eof, bit typed, bit ov, bit [7:0] ob,
                                  bit it, bit [14:0] npc);
    dir_row_t row;
    row.width = w;
    row.req = '{op, addr, data, ib, eof};
    row.typed = typed;
    row.want = '{ov, ob, it, 1'b0, npc};
    dir_rows.push_back(row);
  endfunction

  function automatic sms_req_t rand_req(bit op);
    sms_req_t r;
    r.opcode = op;
    r.load_address = 15'($urandom);
    r.load_data = $urandom;
    r.in_byte = 8'($urandom);
    r.in_eof = ($urandom_range(0, 4) == 0);
    return r;
  endfunction

  function automatic bit [14:0] pick_addr(bit [14:0] pc);
    case ($urandom_range(0, 2))
      0: return 15'(pc + 15'($urandom_range(0, 47)) - 15'd8);
      1: return 15'(15'd2048 + 15'($urandom_range(0, 63)));
      default: return 15'($urandom);
    endcase
  endfunction

  // Send one request in bursts, record its expected result on acceptance
  task automatic send_req(sms_req_t r, bit typed, step_result_t want);
    step_result_t got;
    int           gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
    end
    in_valid     <= 1'b1;
    opcode       <= r.opcode;
    load_address <= r.load_address;
    load_data    <= r.load_data;
    in_byte      <= r.in_byte;
    in_eof       <= r.in_eof;
    do @(posedge clk); while (in_stall);
    burst_left--;
    got = subleq_exec(r, 1'b1);
    pending_results.push_back(typed ? want : got);
    items_sent++;
  endtask

  task automatic load_word(bit [14:0] addr, bit [31:0] data);
    sms_req_t r;
    r = rand_req(OP_LOAD);
    r.load_address = addr;
    r.load_data = data;
    send_req(r, 1'b0, '0);
  endtask

  // Step request; with guard set, plant a jump first if the step would halt
  task automatic run_step(bit guard);
    sms_req_t     r;
    step_result_t probe;
    bit [31:0]    msk, x;
    bit [14:0]    pc;
    r = rand_req(OP_STEP);
    probe = subleq_exec(r, 1'b0);
    if (guard && probe.halted) begin
      msk = word_mask(width_reg);
      x = $urandom_range(0, 32767) & msk;
      if (x == msk) x = 32'd0;
      pc = pc_img;
      load_word(pc, x);
      load_word(15'(pc + 15'd1), x);
      load_word(15'(pc + 15'd2), $urandom_range(0, 32764));
    end
    send_req(r, 1'b0, '0);
  endtask

  // Width change only once the core has drained
  task automatic set_width(bit [5:0] w);
    in_valid <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_reg = w;
    width_writes++;
  endtask

  // Result checker: oldest expectation against each accepted result
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with no request outstanding");
        errors++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_valid !== oldest.out_valid) begin
          $error("out_valid: expected %0h, got %0h", oldest.out_valid, out_valid);
          errors++;
        end
        if (out_byte !== oldest.out_byte) begin
          $error("out_byte: expected %0h, got %0h", oldest.out_byte, out_byte);
          errors++;
        end
        if (input_taken !== oldest.input_taken) begin
          $error("input_taken: expected %0h, got %0h", oldest.input_taken, input_taken);
          errors++;
        end
        if (halted !== oldest.halted) begin
          $error("halted: expected %0h, got %0h", oldest.halted, halted);
          errors++;
        end
        if (next_pc !== oldest.next_pc) begin
          $error("next_pc: expected %0h, got %0h", oldest.next_pc, next_pc);
          errors++;
        end
      end
    end
  end

  // Result stall: modes of free flow, light, heavy and periodic back-pressure
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(50, 300);
    end else begin
      stall_left--;
    end
    stall_phase = (stall_phase + 1) % 7;
    case (stall_mode)
      0: res_stall <= 1'b0;
      1: res_stall <= ($urandom_range(0, 3) == 0);
      2: res_stall <= ($urandom_range(0, 9) < 6);
      default: res_stall <= (stall_phase < 3);
    endcase
  end

  initial begin
    bit [5:0]  phase_widths [10];
    bit [31:0] msk, av, bv, cv;
    bit [14:0] pc, aa, bb;
    int        kind;
    int        target;
    int        dir_count;

    phase_widths = '{6'd8, 6'd32, 6'd0, 6'd63, 6'd7, 6'd33, 6'd15, 6'd24, 6'd31, 6'd9};
    rst          = 1'b1;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    in_valid     = 1'b0;
    opcode       = OP_LOAD;
    load_address = '0;
    load_data    = '0;
    in_byte      = '0;
    in_eof       = 1'b0;
    width_reg    = 6'd16;
    phase_widths[6] = 6'($urandom_range(8, 32));
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table: reset state, input/output/subtract, eof, pc wrap, width masking
    add_row(6'd16, OP_STEP, 15'd0,     32'd0,        8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 15'd0);
    add_row(6'd16, OP_LOAD, 15'd0,     32'hFFFFFFFF, 8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 15'd0);
    add_row(6'd16, OP_LOAD, 15'd1,     32'h12340010, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    add_row(6'd16, OP_STEP, 15'd0,     32'd0,        8'hA5, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1, 15'd3);
    add_row(6'd16, OP_LOAD, 15'd3,     32'd16,       8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    add_row(6'd16, OP_LOAD, 15'd4,     32'h0000FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    add_row(6'd16, OP_STEP, 15'd0,     32'd0,        8'h00, 1'b0, 1'b1, 1'b1, 8'hA5, 1'b0, 15'd6);
    add_row(6'd16, OP_LOAD, 15'd6,     32'h0000FFFF, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    add_row(6'd16, OP_LOAD, 15'd7,     32'd17,       8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    add_row(6'd16, OP_STEP, 15'd0,     32'd0,        8'h5A, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 15'd9);
    add_row(6'd16, OP_LOAD, 15'd9,     32'd16,       8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    add_row(6'd16, OP_LOAD, 15'd10,    32'd17,       8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    add_row(6'd16, OP_LOAD, 15'd11,    32'h00007FFF, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    // negative difference jumps to the top address
    add_row(6'd16, OP_STEP, 15'd0,     32'd0,        8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 15'h7FFF);
    add_row(6'd16, OP_LOAD, 15'h7FFF,  32'd17,       8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    add_row(6'd16, OP_LOAD, 15'd0,     32'd17,       8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    add_row(6'd16, OP_LOAD, 15'd1,     32'd40,       8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    // operand words wrap past the top address; zero difference jumps
    add_row(6'd16, OP_STEP, 15'd0,     32'd0,        8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 15'd40);
    add_row(6'd8,  OP_LOAD, 15'd40,    32'hABCD0050, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    add_row(6'd8,  OP_LOAD, 15'd41,    32'h00000051, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    add_row(6'd8,  OP_LOAD, 15'd80,    32'd3,        8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    add_row(6'd8,  OP_LOAD, 15'd81,    32'hFFFFFF7F, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    // positive difference falls through
    add_row(6'd8,  OP_STEP, 15'd0,     32'd0,        8'h00, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 15'd43);
    add_row(6'd32, OP_LOAD, 15'd43,    32'hFFFFFFFF, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    add_row(6'd32, OP_LOAD, 15'd44,    32'hFFFFFFFF, 8'h00, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 15'd0);
    // input wins over output; end of file stores a full 32-bit word
    add_row(6'd32, OP_STEP, 15'd0,     32'd0,        8'h81, 1'b1, 1'b1, 1'b0, 8'h00, 1'b1, 15'd46);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].width != width_reg) set_width(dir_rows[i].width);
      send_req(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    end
    dir_count = items_sent;

    // Random programs, one width setting per phase
    foreach (phase_widths[p]) begin
      set_width(phase_widths[p]);
      target = items_sent + 130;
      while (items_sent < target) begin
        msk = word_mask(width_reg);
        pc = pc_img;
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
          // stray writes anywhere, may break the running program
          repeat ($urandom_range(1, 4)) load_word(15'($urandom), $urandom);
        end else begin
          aa = pick_addr(pc);
          bb = ($urandom_range(0, 5) == 0) ? aa : pick_addr(pc);
          av = ($urandom & msk & 32'hFFFF8000) | {17'd0, aa};
          bv = ($urandom & msk & 32'hFFFF8000) | {17'd0, bb};
          if ((av & msk) == msk) av[0] = ~av[0];
          if ((bv & msk) == msk) bv[0] = ~bv[0];
          if (kind <= 3) av = msk;
          else if (kind <= 6) bv = msk;
          cv = $urandom_range(0, 1) ? {17'd0, 15'(pc + 15'($urandom_range(3, 60)))}
                                    : $urandom_range(0, 32764);
          if ($urandom_range(0, 1)) load_word(aa, $urandom_range(0, 1) ? $urandom : 32'd1);
          if ($urandom_range(0, 2) == 0)
            load_word(bb, $urandom_range(0, 1) ? mem_img[aa] : $urandom);
          if ($urandom_range(0, 3) != 0) begin
            load_word(pc, av);
            load_word(15'(pc + 15'd1), bv);
            load_word(15'(pc + 15'd2), cv);
          end
        end
        repeat ($urandom_range(1, 4)) run_step(1'b1);
      end
    end

    // Closing program: jump beyond the address space halts; later steps do nothing
    set_width(6'd32);
    pc = pc_img;
    load_word(pc, 32'd2048);
    load_word(15'(pc + 15'd1), 32'd2048);
    load_word(15'(pc + 15'd2), $urandom | 32'h00008000);
    run_step(1'b0);
    repeat (16) begin
      if ($urandom_range(0, 1)) run_step(1'b0);
      else load_word(15'($urandom), $urandom);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("run: %0d requests (%0d from the directed table), %0d width writes, %0d results",
             items_sent, dir_count, width_writes, results_seen);
    $display("machine halted at the end: %0d, mismatches: %0d", halt_img, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- subleq_machine_step_core.f -----
hdl/sms_pkg.sv
hdl/sms_mem.sv
hdl/subleq_machine_step_core.sv
tb/sv/subleq_machine_step_core_tb.sv
